[design/pfa_pkg.sv]
// Shared constants, codes and controller/datapath handshake types for the partition fit allocator.
package pfa_pkg;

  localparam int MAX_BLOCKS_DEF = 8;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int ACTION_W = 1;
  localparam int INDEX_W  = 3;
  localparam int VALUE_W  = 16;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b1;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_USE = 1'b1;

  localparam logic [COUNT_W-1:0] BLOCKS_RST = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_FINISH
  } pfa_state_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic rd_en;
    logic wr_load;
    logic wr_alloc;
    logic load_out;
  } pfa_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_load;
    logic out_free;
  } pfa_stat_t;

endpackage

[design/pfa_if.sv]
// Valid/ready channel interfaces for request beats and result beats.
interface pfa_in_if import pfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  block_index;
  logic [VALUE_W-1:0]  size_value;
  logic                final_request;

  modport source (output valid, action, block_index, size_value, final_request, input ready);
  modport sink   (input valid, action, block_index, size_value, final_request, output ready);
endinterface

interface pfa_out_if import pfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               placed;
  logic [INDEX_W-1:0] chosen_block;
  logic [VALUE_W-1:0] block_size_before;
  logic               batch_done;

  modport source (output valid, placed, chosen_block, block_size_before, batch_done, input ready);
  modport sink   (input valid, placed, chosen_block, block_size_before, batch_done, output ready);
endinterface

[design/partition_fit_allocator_core.sv]
// Order: a load beat is captured, written to the table and loaded as the result;
// an allocate beat is captured, scans N = active partitions (saturated count), drains,
// updates the chosen partition and loads its result. One beat at a time: the scan reads
// one entry per cycle over the size table's single read port, and a new beat is accepted
// only after the last result loads. With no partition in use, scan and drain are skipped.
// Reset (synchronous, rst_n low): all sizes read as zero, first fit, eight partitions in use.
module partition_fit_allocator_core import pfa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pfa_in_if.sink                in_bus,
  pfa_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  pfa_cmd_t         cmd;
  pfa_stat_t        stat;
  logic [CNT_W-1:0] act_cnt;
  logic [IDX_W-1:0] rd_addr;

  pfa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .act_cnt (act_cnt),
    .cmd     (cmd),
    .rd_addr (rd_addr)
  );

  pfa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .stat      (stat),
    .act_cnt   (act_cnt)
  );

endmodule

[design/pfa_ctrl.sv]
// Sequencer for load, scan, update and result handoff.
module pfa_ctrl import pfa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pfa_stat_t        stat,
  input  logic [CNT_W-1:0] act_cnt,
  output pfa_cmd_t         cmd,
  output logic [IDX_W-1:0] rd_addr
);

  pfa_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign rd_addr = IDX_W'(cnt_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          if (stat.in_load) begin
            state_nxt = ST_LOAD_WR;
          end else if (act_cnt == '0) begin
            state_nxt = ST_UPDATE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LOAD_WR: begin
        cmd.wr_load = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == act_cnt - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.wr_alloc = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r < act_cnt))
    else $error("scan address past active partitions");

  a_scan_leads_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> ($past(state_r) == ST_SCAN))
    else $error("drain entered without a scan");

endmodule

[design/pfa_dp.sv]
// Size table, config registers, fit comparator and result register.
module pfa_dp import pfa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pfa_in_if.sink                in_bus,
  pfa_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  pfa_cmd_t              cmd,
  input  logic [IDX_W-1:0]      rd_addr,
  output pfa_stat_t             stat,
  output logic [CNT_W-1:0]      act_cnt
);

  logic [MODE_W-1:0]    fit_mode_r;
  logic [COUNT_W-1:0]   blocks_r;

  logic [ACTION_W-1:0]  action_r;
  logic [INDEX_W-1:0]   idx_r;
  logic [SIZE_BITS-1:0] req_r;
  logic                 last_r;

  logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] vld_r;
  logic [SIZE_BITS-1:0] mem_q;
  logic                 vld_q;
  logic                 cmp_en_r;
  logic [IDX_W-1:0]     cmp_idx_r;

  logic                 found_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [SIZE_BITS-1:0] best_size_r;

  logic                 out_valid_r;
  logic                 placed_r;
  logic [INDEX_W-1:0]   chosen_r;
  logic [VALUE_W-1:0]   before_r;
  logic                 done_r;

  logic [SIZE_BITS-1:0] rd_data;
  logic                 fits;
  logic                 take;
  logic                 idx_ok;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= FIT_FIRST;
      blocks_r   <= BLOCKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT_MODE:   fit_mode_r <= cfg_wdata[MODE_W-1:0];
        CFG_BLOCKS_USE: blocks_r   <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(blocks_r) > MAX_BLOCKS) begin
      act_cnt = CNT_W'(MAX_BLOCKS);
    end else begin
      act_cnt = CNT_W'(blocks_r);
    end
  end

  assign in_bus.ready  = cmd.in_ready;
  assign stat.in_valid = in_bus.valid;
  assign stat.in_load  = (in_bus.action == ACT_LOAD);
  assign stat.out_free = !out_valid_r || out_bus.ready;

  // request beat latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_bus.action;
      idx_r    <= in_bus.block_index;
      req_r    <= SIZE_BITS'(in_bus.size_value);
      last_r   <= in_bus.final_request;
    end
  end

  assign idx_ok  = (32'(idx_r) < MAX_BLOCKS);
  assign wr_en   = (cmd.wr_load && idx_ok) || (cmd.wr_alloc && found_r);
  assign wr_addr = cmd.wr_load ? IDX_W'(idx_r) : best_idx_r;
  assign wr_data = cmd.wr_load ? req_r : (best_size_r - req_r);

  // size table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_q    <= 1'b0;
      cmp_en_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        vld_q <= vld_r[rd_addr];
      end
      cmp_en_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      cmp_idx_r <= rd_addr;
    end
  end

  assign rd_data = vld_q ? mem_q : '0;
  assign fits    = (rd_data >= req_r);
  assign take    = cmp_en_r && fits &&
                   (!found_r ||
                    ((fit_mode_r == FIT_BEST)  && (rd_data < best_size_r)) ||
                    ((fit_mode_r == FIT_WORST) && (rd_data > best_size_r)));

  // running choice
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.capture) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      best_idx_r  <= '0;
      best_size_r <= '0;
    end else if (take) begin
      best_idx_r  <= cmp_idx_r;
      best_size_r <= rd_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      placed_r <= found_r;
      chosen_r <= INDEX_W'(best_idx_r);
      before_r <= VALUE_W'(best_size_r);
      done_r   <= last_r;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.placed            = placed_r;
  assign out_bus.chosen_block      = chosen_r;
  assign out_bus.block_size_before = before_r;
  assign out_bus.batch_done        = done_r;

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_alloc && found_r) |-> (best_size_r >= req_r))
    else $error("allocation would underflow partition size");

  a_load_no_place: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && (action_r == ACT_LOAD)) |=> !out_bus.placed)
    else $error("load beat reported as placed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out) |-> (!out_valid_r || out_bus.ready))
    else $error("result register overwritten before handoff");

endmodule
